// ===== sv/nmle_pkg.sv =====
// Shared types and constants for the node membership and leader election block.
// Holds role, action and event codes plus the controller/datapath interface structs.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package nmle_pkg;

    localparam int NODE_COUNT = 8;
    localparam int NO_REQUEST = 15;

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int ADDR_W = 4;
    localparam int CNT_W  = 4;
    localparam int RANK_W = 3;
    localparam int ROLE_W = 2;
    localparam int FUNC_W = 4;
    localparam int ACT_W  = 2;

    localparam logic [ROLE_W-1:0] ROLE_DISC = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_MUS  = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_COND = 2'd2;

    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_HANDOUT = 2'd2;

    localparam logic [FUNC_W-1:0] FN_HEARTBEAT = 4'd0;
    localparam logic [FUNC_W-1:0] FN_TIMEOUT   = 4'd1;
    localparam logic [FUNC_W-1:0] FN_NEXT      = 4'd2;
    localparam logic [FUNC_W-1:0] FN_HANDOUT   = 4'd3;
    localparam logic [FUNC_W-1:0] FN_CLOST     = 4'd4;
    localparam logic [FUNC_W-1:0] FN_CSTART    = 4'd5;
    localparam logic [FUNC_W-1:0] FN_CLOWER    = 4'd6;
    localparam logic [FUNC_W-1:0] FN_CCOMMIT   = 4'd7;
    localparam logic [FUNC_W-1:0] FN_PERFORM   = 4'd8;
    localparam logic [FUNC_W-1:0] FN_SETFLAG   = 4'd9;
    localparam logic [FUNC_W-1:0] FN_JOIN      = 4'd10;
    localparam logic [FUNC_W-1:0] FN_RESETCONN = 4'd11;
    localparam logic [FUNC_W-1:0] FN_STEPUP    = 4'd12;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic apply;
        logic scan;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== sv/node_membership_leader_election.sv =====
// Top level of the node membership and leader election block.
// Instantiates nmle_ctrl and nmle_dp and packs the stream and configuration ports.
// Depends on nmle_pkg, nmle_ctrl and nmle_dp.
`default_nettype none

// Each event beat is taken in one at a time. Events that consult the whole role table
// (heartbeat, timeout, next, conductor lost, join and step-up check) walk the table one
// entry per cycle through a single read port before the result is formed; all other
// events skip the walk. A new beat is accepted while the previous result still waits
// on the output. The own_rank register may be written at any time the block is idle
// and is always ready.

module node_membership_leader_election (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // node_index[3:0], node_role[5:4], flag_value[6]
    input  wire  [3:0]  s_axis_tuser,   // func[3:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // action[1:0], target_index[5:2], found[6],
                                        // connected_count[10:7], own_role[12:11]
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_data      // own_rank[2:0]
);

    nmle_pkg::t_dp_cmd    cmd;
    nmle_pkg::t_dp_status status;

    logic [nmle_pkg::ACT_W-1:0]  action;
    logic [nmle_pkg::ADDR_W-1:0] target_index;
    logic                        found;
    logic [nmle_pkg::CNT_W-1:0]  connected_count;
    logic [nmle_pkg::ROLE_W-1:0] own_role;

    assign o_cfg_ready = 1'b1;

    nmle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    nmle_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_func            (s_axis_tuser),
        .i_node_index      (s_axis_tdata[3:0]),
        .i_node_role       (s_axis_tdata[5:4]),
        .i_flag_value      (s_axis_tdata[6]),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_own_rank    (i_cfg_data),
        .o_action          (action),
        .o_target_index    (target_index),
        .o_found           (found),
        .o_connected_count (connected_count),
        .o_own_role        (own_role)
    );

    assign m_axis_tdata = {3'b000, own_role, connected_count, found, target_index, action};

endmodule

`default_nettype wire

// ===== sv/nmle_ctrl.sv =====
// Controller state machine for the node membership and leader election block.
// Sequences capture, apply, table scan and finish, and owns the result valid flag.
// Depends on nmle_pkg.
`default_nettype none

module nmle_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    input  wire  nmle_pkg::t_dp_status i_status,
    output nmle_pkg::t_dp_cmd         o_cmd
);

    nmle_pkg::t_state r_state;
    nmle_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            nmle_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = nmle_pkg::ST_APPLY;
                end
            end
            nmle_pkg::ST_APPLY: begin
                n_state = i_status.need_scan ? nmle_pkg::ST_SCAN : nmle_pkg::ST_FINISH;
            end
            nmle_pkg::ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = nmle_pkg::ST_FINISH;
                end
            end
            nmle_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = nmle_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nmle_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            nmle_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            nmle_pkg::ST_APPLY: begin
                o_cmd.apply = 1'b1;
            end
            nmle_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            nmle_pkg::ST_FINISH: begin
                o_cmd.finish = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nmle_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== sv/nmle_dp.sv =====
// Datapath for the node membership and leader election block.
// Holds the role table, membership state, scan accumulators and the result register.
// Depends on nmle_pkg; driven by commands from nmle_ctrl.
`default_nettype none

module nmle_dp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  nmle_pkg::t_dp_cmd             i_cmd,
    output nmle_pkg::t_dp_status                o_status,
    input  wire  [nmle_pkg::FUNC_W-1:0]         i_func,
    input  wire  [nmle_pkg::ADDR_W-1:0]         i_node_index,
    input  wire  [nmle_pkg::ROLE_W-1:0]         i_node_role,
    input  wire                                 i_flag_value,
    input  wire                                 i_cfg_we,
    input  wire  [nmle_pkg::RANK_W-1:0]         i_cfg_own_rank,
    output logic [nmle_pkg::ACT_W-1:0]          o_action,
    output logic [nmle_pkg::ADDR_W-1:0]         o_target_index,
    output logic                                o_found,
    output logic [nmle_pkg::CNT_W-1:0]          o_connected_count,
    output logic [nmle_pkg::ROLE_W-1:0]         o_own_role
);

    localparam int AW = nmle_pkg::ADDR_W;
    localparam int IW = nmle_pkg::IDX_W;

    logic [nmle_pkg::ROLE_W-1:0] r_role [nmle_pkg::NODE_COUNT];
    logic [nmle_pkg::CNT_W-1:0]  r_count;
    logic [nmle_pkg::CNT_W-1:0]  n_count;
    logic                        r_req;
    logic                        n_req;
    logic [AW-1:0]               r_claim;
    logic [AW-1:0]               n_claim;
    logic                        r_link;
    logic                        n_link;
    logic [IW-1:0]               r_rr;
    logic [IW-1:0]               n_rr;
    logic [nmle_pkg::RANK_W-1:0] r_own_rank;

    logic [nmle_pkg::FUNC_W-1:0] r_func;
    logic [AW-1:0]               r_idx;
    logic [nmle_pkg::ROLE_W-1:0] r_nrole;
    logic                        r_flag;

    logic [IW-1:0]               r_scan_cnt;
    logic                        r_has_cond;
    logic                        r_foreign;
    logic [1:0]                  r_mus_cnt;
    logic [IW-1:0]               r_low;
    logic                        r_found;
    logic [IW-1:0]               r_target;

    logic [nmle_pkg::ACT_W-1:0]  r_out_action;
    logic [AW-1:0]               r_out_target;
    logic                        r_out_found;
    logic [nmle_pkg::CNT_W-1:0]  r_out_count;
    logic [nmle_pkg::ROLE_W-1:0] r_out_role;

    logic [AW-1:0]               own_addr;
    logic                        own_ok;
    logic                        idx_ok;
    logic                        hb_ok;
    logic                        to_ok;
    logic [IW:0]                 nxt_sum;
    logic [IW:0]                 nxt_wrap;
    logic [IW-1:0]               scan_addr;
    logic [AW-1:0]               rd_addr;
    logic [nmle_pkg::ROLE_W-1:0] rd_role;
    logic                        step_ok;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [nmle_pkg::ROLE_W-1:0] wr_role;
    logic                        own_wr;
    logic [nmle_pkg::ROLE_W-1:0] own_wr_role;
    logic [nmle_pkg::ACT_W-1:0]  fin_action;
    logic [AW-1:0]               fin_target;
    logic                        fin_found;

    assign own_addr = AW'(r_own_rank);
    assign own_ok   = own_addr < AW'(nmle_pkg::NODE_COUNT);
    assign idx_ok   = r_idx < AW'(nmle_pkg::NODE_COUNT);
    assign hb_ok    = idx_ok && (r_nrole <= nmle_pkg::ROLE_COND);
    assign to_ok    = idx_ok && (r_idx != own_addr);

    assign nxt_sum  = (IW + 1)'(r_rr) + (IW + 1)'(r_scan_cnt) + (IW + 1)'(1);
    assign nxt_wrap = (nxt_sum >= (IW + 1)'(nmle_pkg::NODE_COUNT)) ?
                      nxt_sum - (IW + 1)'(nmle_pkg::NODE_COUNT) : nxt_sum;
    assign scan_addr = (r_func == nmle_pkg::FN_NEXT) ? nxt_wrap[IW-1:0] : r_scan_cnt;

    always_comb begin
        if (i_cmd.apply) begin
            rd_addr = r_idx;
        end else if (i_cmd.scan) begin
            rd_addr = AW'(scan_addr);
        end else begin
            rd_addr = own_addr;
        end
    end

    assign rd_role = (rd_addr < AW'(nmle_pkg::NODE_COUNT)) ?
                     r_role[rd_addr[IW-1:0]] : nmle_pkg::ROLE_DISC;

    assign step_ok = !r_req && !r_has_cond && (r_mus_cnt == 2'd2) && r_link &&
                     (AW'(r_low) == own_addr);

    always_comb begin
        o_status.scan_last = (r_scan_cnt == IW'(nmle_pkg::NODE_COUNT - 1));
        case (r_func)
            nmle_pkg::FN_HEARTBEAT, nmle_pkg::FN_TIMEOUT, nmle_pkg::FN_NEXT,
            nmle_pkg::FN_CLOST, nmle_pkg::FN_JOIN, nmle_pkg::FN_STEPUP: begin
                o_status.need_scan = 1'b1;
            end
            default: begin
                o_status.need_scan = 1'b0;
            end
        endcase
    end

    always_comb begin
        own_wr      = 1'b0;
        own_wr_role = nmle_pkg::ROLE_MUS;
        fin_action  = nmle_pkg::ACT_NONE;
        fin_target  = '0;
        fin_found   = 1'b0;
        case (r_func)
            nmle_pkg::FN_HEARTBEAT, nmle_pkg::FN_STEPUP: begin
                if (step_ok) begin
                    own_wr      = 1'b1;
                    own_wr_role = nmle_pkg::ROLE_COND;
                    fin_action  = nmle_pkg::ACT_START;
                end
            end
            nmle_pkg::FN_TIMEOUT: begin
                if (to_ok && (rd_role == nmle_pkg::ROLE_MUS) && step_ok) begin
                    own_wr      = 1'b1;
                    own_wr_role = nmle_pkg::ROLE_COND;
                    fin_action  = nmle_pkg::ACT_START;
                end
            end
            nmle_pkg::FN_NEXT: begin
                if (r_found) begin
                    fin_found  = 1'b1;
                    fin_target = AW'(r_target);
                end
            end
            nmle_pkg::FN_HANDOUT: begin
                if (idx_ok && (r_idx == own_addr)) begin
                    fin_action = nmle_pkg::ACT_START;
                end
            end
            nmle_pkg::FN_CLOST: begin
                own_wr = (r_mus_cnt == 2'd2);
            end
            nmle_pkg::FN_PERFORM: begin
                if (r_claim != AW'(nmle_pkg::NO_REQUEST)) begin
                    own_wr     = 1'b1;
                    fin_action = nmle_pkg::ACT_HANDOUT;
                    fin_target = r_claim;
                end
            end
            nmle_pkg::FN_JOIN: begin
                fin_found = r_foreign;
            end
            default: begin
                own_wr = 1'b0;
            end
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_role = r_nrole;
        if (i_cmd.apply) begin
            case (r_func)
                nmle_pkg::FN_HEARTBEAT: begin
                    wr_en = hb_ok;
                end
                nmle_pkg::FN_TIMEOUT: begin
                    wr_en   = to_ok;
                    wr_role = nmle_pkg::ROLE_DISC;
                end
                nmle_pkg::FN_HANDOUT: begin
                    wr_en   = idx_ok;
                    wr_role = nmle_pkg::ROLE_COND;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end else if (i_cmd.scan) begin
            wr_en   = (r_func == nmle_pkg::FN_CLOST) && (rd_role == nmle_pkg::ROLE_MUS);
            wr_addr = AW'(scan_addr);
            wr_role = nmle_pkg::ROLE_DISC;
        end else if (i_cmd.finish) begin
            wr_en   = own_wr && own_ok;
            wr_addr = own_addr;
            wr_role = own_wr_role;
        end
    end

    always_comb begin
        n_count = r_count;
        n_req   = r_req;
        n_claim = r_claim;
        n_link  = r_link;
        n_rr    = r_rr;
        if (i_cmd.apply) begin
            if ((r_func == nmle_pkg::FN_HEARTBEAT) && hb_ok &&
                (rd_role == nmle_pkg::ROLE_DISC) &&
                (r_count < nmle_pkg::CNT_W'(nmle_pkg::NODE_COUNT))) begin
                n_count = r_count + nmle_pkg::CNT_W'(1);
            end
            if ((r_func == nmle_pkg::FN_TIMEOUT) && to_ok &&
                (rd_role != nmle_pkg::ROLE_DISC) && (r_count != '0)) begin
                n_count = r_count - nmle_pkg::CNT_W'(1);
            end
        end else if (i_cmd.finish) begin
            case (r_func)
                nmle_pkg::FN_NEXT: begin
                    if (r_found) begin
                        n_rr = r_target;
                    end
                end
                nmle_pkg::FN_CSTART: begin
                    n_req   = 1'b1;
                    n_claim = r_idx;
                end
                nmle_pkg::FN_CLOWER: begin
                    if (r_idx < r_claim) begin
                        n_claim = r_idx;
                    end
                end
                nmle_pkg::FN_PERFORM: begin
                    n_claim = AW'(nmle_pkg::NO_REQUEST);
                end
                nmle_pkg::FN_SETFLAG: begin
                    n_req = r_flag;
                end
                nmle_pkg::FN_JOIN: begin
                    n_link = 1'b1;
                end
                nmle_pkg::FN_RESETCONN: begin
                    n_link  = 1'b0;
                    n_count = nmle_pkg::CNT_W'(1);
                end
                default: begin
                    n_link = r_link;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < nmle_pkg::NODE_COUNT; i++) begin
            if (!i_rst_n) begin
                r_role[i] <= nmle_pkg::ROLE_DISC;
            end else if (wr_en && (wr_addr == AW'(i))) begin
                r_role[i] <= wr_role;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= nmle_pkg::CNT_W'(1);
            r_req      <= 1'b0;
            r_claim    <= AW'(nmle_pkg::NO_REQUEST);
            r_link     <= 1'b0;
            r_rr       <= '0;
            r_own_rank <= '0;
        end else begin
            r_count <= n_count;
            r_req   <= n_req;
            r_claim <= n_claim;
            r_link  <= n_link;
            r_rr    <= n_rr;
            if (i_cfg_we) begin
                r_own_rank <= i_cfg_own_rank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_func;
            r_idx   <= i_node_index;
            r_nrole <= i_node_role;
            r_flag  <= i_flag_value;
        end
        if (i_cmd.apply) begin
            r_scan_cnt <= '0;
            r_has_cond <= 1'b0;
            r_foreign  <= 1'b0;
            r_mus_cnt  <= 2'd0;
            r_low      <= '0;
            r_found    <= 1'b0;
            r_target   <= '0;
        end else if (i_cmd.scan) begin
            r_scan_cnt <= r_scan_cnt + IW'(1);
            if (rd_role == nmle_pkg::ROLE_COND) begin
                r_has_cond <= 1'b1;
                if (AW'(scan_addr) != own_addr) begin
                    r_foreign <= 1'b1;
                end
            end
            if (rd_role == nmle_pkg::ROLE_MUS) begin
                if (r_mus_cnt == 2'd0) begin
                    r_low <= scan_addr;
                end
                if (r_mus_cnt != 2'd2) begin
                    r_mus_cnt <= r_mus_cnt + 2'd1;
                end
            end
            if (!r_found && (rd_role != nmle_pkg::ROLE_DISC)) begin
                r_found  <= 1'b1;
                r_target <= scan_addr;
            end
        end
        if (i_cmd.finish) begin
            r_out_action <= fin_action;
            r_out_target <= fin_target;
            r_out_found  <= fin_found;
            r_out_count  <= n_count;
            r_out_role   <= (own_wr && own_ok) ? own_wr_role : rd_role;
        end
    end

    assign o_action          = r_out_action;
    assign o_target_index    = r_out_target;
    assign o_found           = r_out_found;
    assign o_connected_count = r_out_count;
    assign o_own_role        = r_out_role;

endmodule

`default_nettype wire

// ===== sv/nmle_checker.sv =====
// Port-level checker for the node membership and leader election block.
// Watches the stream ports over time and is bound to the top level below.
// Depends on nmle_pkg and node_membership_leader_election.
`default_nettype none

module nmle_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result beat changed while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Event beat accepted while the previous event is in progress.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[10:7] <= 4'(nmle_pkg::NODE_COUNT))
        else $error("Connected count above the node count.");

    a_start_is_conductor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == nmle_pkg::ACT_START)
        |-> m_axis_tdata[12:11] == nmle_pkg::ROLE_COND)
        else $error("Start signaled while own role is not conductor.");

    a_action_no_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != nmle_pkg::ACT_NONE) |-> !m_axis_tdata[6])
        else $error("Found flag set on a result that carries an action.");

endmodule

bind node_membership_leader_election nmle_checker u_nmle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
